// File: sv/psw_pkg.sv
// Shared widths, constants and types for the priority schedule block.
`timescale 1ns / 1ps

package psw_pkg;

  // Default store capacity in jobs
  localparam int MAX_ENTRIES_DEF = 32;

  // Field widths of one job and one result
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int POS_W   = 6;
  localparam int TIME_W  = 21;
  localparam int AVGW_W  = 28;
  localparam int AVGT_W  = 29;
  localparam int FRAC_W  = 8;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_FIELD_W = POS_W + BURST_W + PRIO_W + 2 * TIME_W + AVGW_W + AVGT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // One stored job; the layout matches the input tdata packing
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } job_t;

  localparam int JOB_W = $bits(job_t);

endpackage

// File: sv/psw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module psw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry and register one read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/psw_div.sv
// Restoring divider, one quotient bit per cycle, shared by both averages.
`timescale 1ns / 1ps

module psw_div #(
  parameter int DVW = 36,
  parameter int CW  = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [CW-1:0]  divisor,
  output logic           busy,
  output logic [DVW-1:0] quotient
);

  localparam int NW = $clog2(DVW + 1);

  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic [DVW-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0]  rem_r, rem_nxt;
  logic [CW:0]    rem_sh;
  logic [CW:0]    rem_sub;
  logic           ge;

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVW-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    ge      = (rem_sh >= {1'b0, divisor});
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = NW'(DVW);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - NW'(1);
      dvd_nxt = {dvd_r[DVW-2:0], ge};
      rem_nxt = ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
    end
  end

  // Hold the bit counter under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Advance dividend and partial remainder
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = dvd_r;

endmodule

// File: sv/priority_schedule_wait_times.sv
// Top level: job store, selection-sort sequencer, result emission and averages.
// Jobs load one per cycle while in_tready is high; after the job marked last the store is
//   selection-sorted, then each result is read, built and held until its output transfer; the
//   final result first waits for two serial divisions, one quotient bit a cycle.
// Sets: one set at a time; in_tready is low from the last job until the final transfer.
// Reset (rst_n, synchronous, active low) clears control state; the job store is not cleared.
`timescale 1ns / 1ps

module priority_schedule_wait_times
  import psw_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: burst[15:0], prio[23:16]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  input  logic                   in_tlast,
  output logic                   in_tready,
  // out_tdata: position[5:0], burst_out[21:6], prio_out[29:22], waiting[50:30],
  //   turnaround[71:51], avg_waiting[99:72], avg_turnaround[128:100], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: dropped
  output logic                   out_tuser,
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready
);

  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int BMAX = (1 << BURST_W) - 1;
  localparam int EW  = $clog2(MAX_ENTRIES * BMAX + 1);
  localparam int SW  = $clog2(MAX_ENTRIES * MAX_ENTRIES * BMAX + 1);
  localparam int DVW = SW + FRAC_W;

  typedef enum logic [12:0] {
    S_LOAD = 13'b0000000000001,
    S_RDA  = 13'b0000000000010,
    S_GETA = 13'b0000000000100,
    S_SCAN = 13'b0000000001000,
    S_SWB  = 13'b0000000010000,
    S_SWA  = 13'b0000000100000,
    S_ORD  = 13'b0000001000000,
    S_OUT  = 13'b0000010000000,
    S_DWG  = 13'b0000100000000,
    S_DWR  = 13'b0001000000000,
    S_DTG  = 13'b0010000000000,
    S_DTR  = 13'b0100000000000,
    S_SEND = 13'b1000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [IW-1:0]     a_r, a_nxt;
  logic [IW-1:0]     b_r, b_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [IW-1:0]     best_idx_r, best_idx_nxt;
  job_t              best_r, best_nxt;
  job_t              cur_r, cur_nxt;
  logic [EW-1:0]     elapsed_r, elapsed_nxt;
  logic [SW-1:0]     sumw_r, sumw_nxt;
  logic [SW-1:0]     sumt_r, sumt_nxt;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [BURST_W-1:0] burst_r, burst_nxt;
  logic [PRIO_W-1:0]  prio_r, prio_nxt;
  logic [TIME_W-1:0]  wait_r, wait_nxt;
  logic [TIME_W-1:0]  turn_r, turn_nxt;
  logic [AVGW_W-1:0]  avgw_r, avgw_nxt;
  logic [AVGT_W-1:0]  avgt_r, avgt_nxt;
  logic               drop_r, drop_nxt;
  logic               eor_r, eor_nxt;

  // Store port signals
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [JOB_W-1:0]  ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [JOB_W-1:0]  ram_rdata;
  job_t              rd_job;

  // Divider signals
  logic              div_start;
  logic [DVW-1:0]    div_dividend;
  logic              div_busy;
  logic [DVW-1:0]    div_quot;

  logic              in_xfer;
  logic              out_xfer;
  logic [CW-1:0]     a_p1;
  logic [CW-1:0]     b_p1;
  logic [CW-1:0]     k_p1;
  logic [EW-1:0]     turn_full;

  assign rd_job    = job_t'(ram_rdata);
  assign in_tready = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_SEND);
  assign in_xfer   = in_tvalid & in_tready;
  assign out_xfer  = out_tvalid & out_tready;
  assign a_p1      = CW'(a_r) + CW'(1);
  assign b_p1      = CW'(b_r) + CW'(1);
  assign k_p1      = CW'(k_r) + CW'(1);
  assign turn_full = elapsed_r + EW'(rd_job.burst);

  psw_ram #(
    .WIDTH (JOB_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  psw_div #(
    .DVW (DVW),
    .CW  (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // Sequencer: load, sort, emit, and divide for the averages
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    k_nxt        = k_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    cur_nxt      = cur_r;
    elapsed_nxt  = elapsed_r;
    sumw_nxt     = sumw_r;
    sumt_nxt     = sumt_r;
    pos_nxt      = pos_r;
    burst_nxt    = burst_r;
    prio_nxt     = prio_r;
    wait_nxt     = wait_r;
    turn_nxt     = turn_r;
    avgw_nxt     = avgw_r;
    avgt_nxt     = avgt_r;
    drop_nxt     = drop_r;
    eor_nxt      = eor_r;
    ram_we       = 1'b0;
    ram_waddr    = cnt_r[IW-1:0];
    ram_wdata    = in_tdata;
    ram_raddr    = '0;
    div_start    = 1'b0;
    div_dividend = {sumw_r, FRAC_W'(0)};

    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          // Store the job, or drop it when full
          if (cnt_r < CW'(MAX_ENTRIES)) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            a_nxt       = '0;
            k_nxt       = '0;
            elapsed_nxt = '0;
            sumw_nxt    = '0;
            sumt_nxt    = '0;
            state_nxt   = S_RDA;
          end
        end
      end
      S_RDA: begin
        ram_raddr = a_r;
        state_nxt = S_GETA;
      end
      S_GETA: begin
        // Take entry a as the current best, start the scan after it
        cur_nxt      = rd_job;
        best_nxt     = rd_job;
        best_idx_nxt = a_r;
        b_nxt        = a_p1[IW-1:0];
        ram_raddr    = a_p1[IW-1:0];
        state_nxt    = (a_p1 < cnt_r) ? S_SCAN : S_SWB;
      end
      S_SCAN: begin
        // Strict less-than keeps the earliest minimum
        if (rd_job.prio < best_r.prio) begin
          best_nxt     = rd_job;
          best_idx_nxt = b_r;
        end
        if (b_p1 < cnt_r) begin
          b_nxt     = b_p1[IW-1:0];
          ram_raddr = b_p1[IW-1:0];
        end else begin
          state_nxt = S_SWB;
        end
      end
      S_SWB: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_r;
        ram_wdata = cur_r;
        state_nxt = S_SWA;
      end
      S_SWA: begin
        ram_we    = 1'b1;
        ram_waddr = a_r;
        ram_wdata = best_r;
        if (a_p1 < cnt_r) begin
          a_nxt     = a_p1[IW-1:0];
          state_nxt = S_RDA;
        end else begin
          state_nxt = S_ORD;
        end
      end
      S_ORD: begin
        ram_raddr = k_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Build the result and advance the running sums
        pos_nxt     = POS_W'(k_p1);
        burst_nxt   = rd_job.burst;
        prio_nxt    = rd_job.prio;
        wait_nxt    = TIME_W'(elapsed_r);
        turn_nxt    = TIME_W'(turn_full);
        avgw_nxt    = '0;
        avgt_nxt    = '0;
        drop_nxt    = ovf_r;
        eor_nxt     = (k_p1 == cnt_r);
        sumw_nxt    = sumw_r + SW'(elapsed_r);
        sumt_nxt    = sumt_r + SW'(turn_full);
        elapsed_nxt = turn_full;
        state_nxt   = (k_p1 == cnt_r) ? S_DWG : S_SEND;
      end
      S_DWG: begin
        div_start    = 1'b1;
        div_dividend = {sumw_r, FRAC_W'(0)};
        state_nxt    = S_DWR;
      end
      S_DWR: begin
        if (!div_busy) begin
          avgw_nxt  = AVGW_W'(div_quot);
          state_nxt = S_DTG;
        end
      end
      S_DTG: begin
        div_start    = 1'b1;
        div_dividend = {sumt_r, FRAC_W'(0)};
        state_nxt    = S_DTR;
      end
      S_DTR: begin
        if (!div_busy) begin
          avgt_nxt  = AVGT_W'(div_quot);
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        // Hold the result until the transfer completes
        if (out_xfer) begin
          if (eor_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_p1[IW-1:0];
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Sort, sum and result registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    k_r        <= k_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    cur_r      <= cur_nxt;
    elapsed_r  <= elapsed_nxt;
    sumw_r     <= sumw_nxt;
    sumt_r     <= sumt_nxt;
    pos_r      <= pos_nxt;
    burst_r    <= burst_nxt;
    prio_r     <= prio_nxt;
    wait_r     <= wait_nxt;
    turn_r     <= turn_nxt;
    avgw_r     <= avgw_nxt;
    avgt_r     <= avgt_nxt;
    drop_r     <= drop_nxt;
    eor_r      <= eor_nxt;
  end

  assign out_tdata = {{OUT_PAD_W{1'b0}}, avgt_r, avgw_r, turn_r, wait_r,
                      prio_r, burst_r, pos_r};
  assign out_tuser = drop_r;
  assign out_tlast = eor_r;

endmodule

// File: dv/psw_sched_checker.sv
// Checker for the priority schedule block: predicts each schedule and compares results.
`timescale 1ns / 1ps

module psw_sched_checker
  import psw_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: burst[15:0], prio[23:16]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  input  logic                   in_tlast,
  input  logic                   in_tready,
  // out_tdata: position, burst_out, prio_out, waiting, turnaround, avg_waiting,
  //   avg_turnaround, zero pad
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: dropped
  input  logic                   out_tuser,
  input  logic                   out_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  output int                     fail_count,
  output int                     pending
);

  // Bit offsets of the result fields in out_tdata
  localparam int POS_LO   = 0;
  localparam int BURST_LO = POS_LO + POS_W;
  localparam int PRIO_LO  = BURST_LO + BURST_W;
  localparam int WAIT_LO  = PRIO_LO + PRIO_W;
  localparam int TURN_LO  = WAIT_LO + TIME_W;
  localparam int AVGW_LO  = TURN_LO + TIME_W;
  localparam int AVGT_LO  = AVGW_LO + AVGW_W;

  typedef struct {
    logic [POS_W-1:0]   position;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  waiting;
    logic [TIME_W-1:0]  turnaround;
    logic [AVGW_W-1:0]  avg_wait;
    logic [AVGT_W-1:0]  avg_turn;
    logic               dropped;
    logic               end_of_run;
  } sched_row_t;

  // Shadow of the job store and set bookkeeping
  logic [BURST_W-1:0] burst_mem [MAX_ENTRIES];
  logic [PRIO_W-1:0]  prio_mem  [MAX_ENTRIES];
  int unsigned        held_jobs;
  bit                 set_spilled;
  int                 errors;

  // Service-order rows still to come out of the block
  sched_row_t schedule_rows [$];

  // Selection sort on priority, swapping in place (ties keep this sort's order)
  task automatic order_by_priority(int unsigned n);
    int unsigned        best;
    logic [PRIO_W-1:0]  tp;
    logic [BURST_W-1:0] tb;
    for (int unsigned a = 0; a < n; a++) begin
      best = a;
      for (int unsigned b = a + 1; b < n; b++) begin
        if (prio_mem[b] < prio_mem[best]) begin
          best = b;
        end
      end
      tp = prio_mem[a];
      tb = burst_mem[a];
      prio_mem[a]     = prio_mem[best];
      prio_mem[best]  = tp;
      burst_mem[a]    = burst_mem[best];
      burst_mem[best] = tb;
    end
  endtask

  // Order the held jobs and queue one row per job with waiting and turnaround times
  task automatic schedule_set();
    logic [63:0] elapsed;
    logic [63:0] turn;
    logic [63:0] sum_wait;
    logic [63:0] sum_turn;
    logic [63:0] n;
    sched_row_t  row;
    n = held_jobs;
    order_by_priority(held_jobs);
    // First pass: totals for the averages
    elapsed  = 0;
    sum_wait = 0;
    sum_turn = 0;
    for (int unsigned k = 0; k < held_jobs; k++) begin
      turn     = elapsed + burst_mem[k];
      sum_wait += elapsed;
      sum_turn += turn;
      elapsed  = turn;
    end
    // Second pass: build the rows; averages go on the final one only
    elapsed = 0;
    for (int unsigned k = 0; k < held_jobs; k++) begin
      turn           = elapsed + burst_mem[k];
      row.position   = POS_W'(k + 1);
      row.burst      = burst_mem[k];
      row.prio       = prio_mem[k];
      row.waiting    = elapsed[TIME_W-1:0];
      row.turnaround = turn[TIME_W-1:0];
      row.dropped    = set_spilled;
      row.end_of_run = (k + 1 == held_jobs);
      if (row.end_of_run) begin
        row.avg_wait = AVGW_W'((sum_wait << FRAC_W) / n);
        row.avg_turn = AVGT_W'((sum_turn << FRAC_W) / n);
      end else begin
        row.avg_wait = '0;
        row.avg_turn = '0;
      end
      schedule_rows.push_back(row);
      elapsed = turn;
    end
    held_jobs   = 0;
    set_spilled = 1'b0;
  endtask

  task automatic check_field(string label, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin : sample
    sched_row_t row;
    job_t       job;
    if (!rst_n) begin
      held_jobs   = 0;
      set_spilled = 1'b0;
      schedule_rows.delete();
    end else begin
      // Compare a result transfer with the oldest pending row
      if (out_tvalid && out_tready) begin
        if (schedule_rows.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got tdata %0h", $time, out_tdata);
        end else begin
          row = schedule_rows.pop_front();
          check_field("position", row.position, out_tdata[POS_LO +: POS_W]);
          check_field("burst_out", row.burst, out_tdata[BURST_LO +: BURST_W]);
          check_field("prio_out", row.prio, out_tdata[PRIO_LO +: PRIO_W]);
          check_field("waiting", row.waiting, out_tdata[WAIT_LO +: TIME_W]);
          check_field("turnaround", row.turnaround, out_tdata[TURN_LO +: TIME_W]);
          check_field("avg_waiting", row.avg_wait, out_tdata[AVGW_LO +: AVGW_W]);
          check_field("avg_turnaround", row.avg_turn, out_tdata[AVGT_LO +: AVGT_W]);
          check_field("dropped", row.dropped, out_tuser);
          check_field("end_of_run", row.end_of_run, out_tlast);
        end
      end
      // Store or drop an accepted job; the last one closes the set
      if (in_tvalid && in_tready) begin
        job = in_tdata[JOB_W-1:0];
        if (held_jobs < MAX_ENTRIES) begin
          burst_mem[held_jobs] = job.burst;
          prio_mem[held_jobs]  = job.prio;
          held_jobs++;
        end else begin
          set_spilled = 1'b1;
        end
        if (in_tlast && held_jobs != 0) begin
          schedule_set();
        end
      end
    end
    fail_count <= errors;
    pending    <= schedule_rows.size();
  end

endmodule

// File: dv/priority_schedule_wait_times_tb.sv
// Testbench top for the priority schedule block: clock, reset, job stimulus and verdict.
`timescale 1ns / 1ps

module priority_schedule_wait_times_tb;
  import psw_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int RAND_ITEMS   = 145;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_SPARSE
  } rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tlast;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready;

  int  chk_fails;
  int  chk_pending;
  int  cycle_count = 0;
  bit  rx_hold_req = 1'b0;
  int  burst_left = 0;
  int  rand_items = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  priority_schedule_wait_times u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  psw_sched_checker u_sched_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .fail_count (chk_fails),
    .pending    (chk_pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall modes of random length, plus one long hold-off
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       phase;
    bit       hold_done;
    out_tready = 1'b0;
    mode       = RX_OPEN;
    mode_left  = 0;
    hold_left  = 0;
    phase      = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_EVERY4: out_tready <= (phase % 4 == 0);
          default:   out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [BURST_W-1:0] pick_burst();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BURST_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one job, hold it until the transfer, then pace the sender in bursts
  task automatic push_job(logic [BURST_W-1:0] burst, logic [PRIO_W-1:0] prio, logic last);
    job_t job;
    int   gap;
    job.burst = burst;
    job.prio  = prio;
    @(negedge clk);
    in_tdata  <= job;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Drop valid for a random gap and put noise on the idle bus
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);
      in_tlast  <= 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
    end
  endtask

  // One set of random jobs; narrow priorities make ties likely
  task automatic send_set(int n, bit narrow_prio, bit max_burst);
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    for (int i = 0; i < n; i++) begin
      prio  = narrow_prio ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom_range(0, 255));
      burst = max_burst ? '1 : pick_burst();
      push_job(burst, prio, i == n - 1);
      rand_items++;
    end
  endtask

  initial begin
    int set_idx;
    int n;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    in_tdata  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-job sets at both extremes
    push_job('0, '0, 1'b1);
    push_job('1, '1, 1'b1);
    // Ties around a lower priority, with a full-scale burst
    push_job(16'd100, 8'd5, 1'b0);
    push_job(16'd200, 8'd5, 1'b0);
    push_job(16'd300, 8'd3, 1'b0);
    push_job('1, 8'd5, 1'b1);
    // All priorities equal
    push_job(16'd7, 8'd9, 1'b0);
    push_job(16'd0, 8'd9, 1'b0);
    push_job(16'h8000, 8'd9, 1'b1);
    // Strictly descending priorities
    push_job(16'd1, 8'd255, 1'b0);
    push_job(16'd2, 8'd128, 1'b0);
    push_job(16'd3, 8'd1, 1'b0);
    push_job(16'd4, 8'd0, 1'b1);
    // Alternating bit patterns
    push_job(16'h5555, 8'hAA, 1'b0);
    push_job(16'hAAAA, 8'h55, 1'b1);

    // Random sets; a few fixed shapes cover the hold-off, overflow and full store
    rand_items = 0;
    set_idx    = 0;
    while (rand_items < RAND_ITEMS) begin
      case (set_idx)
        0: begin
          rx_hold_req = 1'b1;
          send_set(6, 1'b0, 1'b0);
        end
        1: send_set(MAX_ENTRIES_DEF + 1, 1'b1, 1'b0);
        3: send_set(MAX_ENTRIES_DEF, 1'b0, 1'b1);
        5: send_set(MAX_ENTRIES_DEF + $urandom_range(2, 4), 1'b0, 1'b0);
        default: begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 32) : $urandom_range(1, 10);
          send_set(n, 1'($urandom_range(0, 1)), 1'b0);
        end
      endcase
      set_idx++;
    end

    // Release the bus and drain
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (chk_fails == 0 && chk_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
